/* rtl/dual_stack_processor_core_assert.svh */
// Assertion macros for the dual-stack processor core checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DUAL_STACK_PROCESSOR_CORE_ASSERT_SVH
`define DUAL_STACK_PROCESSOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dsp_pkg.sv */
// Types and constants of the dual-stack processor core.
// No dependencies.
package dsp_pkg;

  typedef enum logic [4:0] {
    OP_NOP    = 5'd0,
    OP_LIT    = 5'd1,
    OP_DUP    = 5'd2,
    OP_DROP   = 5'd3,
    OP_SWAP   = 5'd4,
    OP_PUSH   = 5'd5,
    OP_POP    = 5'd6,
    OP_JUMP   = 5'd7,
    OP_CALL   = 5'd8,
    OP_CCALL  = 5'd9,
    OP_RETURN = 5'd10,
    OP_EQ     = 5'd11,
    OP_NEQ    = 5'd12,
    OP_LT     = 5'd13,
    OP_GT     = 5'd14,
    OP_FETCH  = 5'd15,
    OP_STORE  = 5'd16,
    OP_ADD    = 5'd17,
    OP_SUB    = 5'd18,
    OP_MUL    = 5'd19,
    OP_DIVMOD = 5'd20,
    OP_AND    = 5'd21,
    OP_OR     = 5'd22,
    OP_XOR    = 5'd23,
    OP_SHIFT  = 5'd24,
    OP_ZRET   = 5'd25,
    OP_END    = 5'd26,
    OP_IN     = 5'd27,
    OP_OUT    = 5'd28,
    OP_CJUMP  = 5'd29
  } op_t;

  localparam logic [31:0] NUM_OPS = 32'd30;

  localparam logic [2:0] ST_RUN      = 3'd0;
  localparam logic [2:0] ST_END      = 3'd1;
  localparam logic [2:0] ST_UNDER    = 3'd2;
  localparam logic [2:0] ST_BAD_OP   = 3'd3;
  localparam logic [2:0] ST_DIV_ZERO = 3'd4;
  localparam logic [2:0] ST_OVER     = 3'd5;
  localparam logic [2:0] ST_BAD_ADDR = 3'd6;

  localparam logic [7:0] CHAR_MASK = 8'hff;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_READ   = 11'b00000000100,
    S_EXEC   = 11'b00000001000,
    S_DIV    = 11'b00000010000,
    S_DIV_WR = 11'b00000100000,
    S_WR2    = 11'b00001000000,
    S_REFILL = 11'b00010000000,
    S_TOP    = 11'b00100000000,
    S_RESP   = 11'b01000000000,
    S_SPARE  = 11'b10000000000
  } state_t;

  // negative amount shifts left, otherwise arithmetic right
  function automatic logic [31:0] shift_op(input logic [31:0] x, input logic [31:0] t);
    logic [31:0] s;
    logic [31:0] r;
    s = 32'd0 - t;
    if (t[31]) begin
      r = (s >= 32'd32) ? 32'd0 : (x << s[4:0]);
    end else if (t >= 32'd32) begin
      r = {32{x[31]}};
    end else begin
      r = 32'($signed(x) >>> t[4:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/dual_stack_processor_core.sv */
// Dual-stack processor core: top level, sequencer and datapath.
// Depends on dsp_pkg and dsp_ram.
//
// Usage:
//  Input channel (in_valid/in_ready): one beat either loads a memory word
//  (in_opcode 0) or executes the instruction at the pc (in_opcode 1).
//  Result channel (out_valid/out_ready): exactly one beat per input beat,
//  carrying the emitted character (if OUT), status, pc, stack top, depth.
//  Flow: loads and steps on a halted core answer straight from idle. An
//  executed instruction passes fetch, operand read, execute, top refill;
//  SWAP adds a second stack write, DIVMOD its bit-serial divider. The main
//  memory read port sets the pace: fetch and the operand word share it.
//  Reset: after rst_n a clearing pass writes zero to every main memory cell,
//  with in_ready low. All stacks and pointers restart empty.
//  Stall: a finished result is held in the output register until taken; a
//  new beat is accepted in the same cycle the old one leaves.
module dual_stack_processor_core #(
  parameter int MEM_WORDS    = 65536,
  parameter int DATA_DEPTH   = 32,
  parameter int RETURN_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [15:0]        in_load_address,
  input  logic signed [31:0] in_load_word,
  input  logic signed [8:0]  in_in_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_out_valid,
  output logic [7:0]         out_out_char,
  output logic [2:0]         out_status,
  output logic [15:0]        out_pc_value,
  output logic signed [31:0] out_top_value,
  output logic [5:0]         out_stack_depth
);

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int DPW = $clog2(DATA_DEPTH + 1);
  localparam int RAW = $clog2(RETURN_DEPTH);
  localparam int RPW = $clog2(RETURN_DEPTH + 1);

  dsp_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]  clr_r, clr_nxt;
  logic [AW-1:0]  pc_r, pc_nxt;
  logic [DPW-1:0] dp_r, dp_nxt;
  logic [RPW-1:0] rp_r, rp_nxt;
  logic [2:0]     halt_r, halt_nxt;
  logic [31:0]    top_r, top_nxt;
  logic           ov_r, ov_nxt;

  logic [31:0]    w_r, w_nxt;
  logic [8:0]     ic_r, ic_nxt;
  logic [31:0]    prod_r, prod_nxt;
  logic           emit_r, emit_nxt;
  logic [7:0]     ch_r, ch_nxt;
  logic [DAW-1:0] wr2_addr_r, wr2_addr_nxt;
  logic [31:0]    wr2_data_r, wr2_data_nxt;
  logic [4:0]     dcnt_r, dcnt_nxt;
  logic [31:0]    dq_r, dq_nxt;
  logic [31:0]    drem_r, drem_nxt;
  logic [31:0]    dd_r, dd_nxt;
  logic           dqneg_r, dqneg_nxt;
  logic           drneg_r, drneg_nxt;

  logic           o_emit_r, o_emit_nxt;
  logic [7:0]     o_char_r, o_char_nxt;
  logic [2:0]     o_status_r, o_status_nxt;
  logic [15:0]    o_pc_r, o_pc_nxt;
  logic [31:0]    o_top_r, o_top_nxt;
  logic [5:0]     o_depth_r, o_depth_nxt;

  // memory ports
  logic           mm_we, mm_re;
  logic [AW-1:0]  mm_waddr, mm_raddr;
  logic [31:0]    mm_wdata, mm_rdata;
  logic           ds_we, ds_re;
  logic [DAW-1:0] ds_waddr, ds_raddr;
  logic [31:0]    ds_wdata, ds_rdata;
  logic           rs_we, rs_re;
  logic [RAW-1:0] rs_waddr, rs_raddr;
  logic [31:0]    rs_wdata, rs_rdata;

  dsp_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_main_mem (
    .clk(clk), .we(mm_we), .waddr(mm_waddr), .wdata(mm_wdata),
    .re(mm_re), .raddr(mm_raddr), .rdata(mm_rdata)
  );

  dsp_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_data_stack (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
    .re(ds_re), .raddr(ds_raddr), .rdata(ds_rdata)
  );

  dsp_ram #(.WIDTH(32), .DEPTH(RETURN_DEPTH)) u_return_stack (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .re(rs_re), .raddr(rs_raddr), .rdata(rs_rdata)
  );

  logic           in_acc, out_acc, slot_free;
  logic [DPW-1:0] dpm1, dpm2, dpp1, dpm2w;
  logic [RPW-1:0] rpm1, rpp1;
  logic [31:0]    pc32, pc1, nxt_pc, n_val, r_val, ic_ext, ma, mb, dq_f, drem_f;
  logic [32:0]    ret_addr, rem_sh;
  logic           dp_ge1, dp_ge2, dp_full, rp_ge1, rp_full, t_ok, lit_ok, ret_ok;
  logic [2:0]     err;
  logic [31:0]    cur_top_ext;
  logic [31:0]    pc_ext, dp_ext;

  assign in_acc    = in_valid & in_ready;
  assign out_acc   = ov_r & out_ready;
  assign slot_free = ~ov_r | out_ready;
  assign in_ready  = (state_r == dsp_pkg::S_IDLE) & slot_free;

  assign dpm1 = dp_r - DPW'(1);
  assign dpm2 = dp_r - DPW'(2);
  assign dpp1 = dp_r + DPW'(1);
  assign rpm1 = rp_r - RPW'(1);
  assign rpp1 = rp_r + RPW'(1);
  assign dpm2w = dpm2;

  assign dp_ge1  = dp_r >= DPW'(1);
  assign dp_ge2  = dp_r >= DPW'(2);
  assign dp_full = dp_r >= DPW'(DATA_DEPTH);
  assign rp_ge1  = rp_r >= RPW'(1);
  assign rp_full = rp_r >= RPW'(RETURN_DEPTH);

  assign pc32     = 32'(pc_r);
  assign pc1      = pc32 + 32'd1;
  assign n_val    = dp_ge2 ? ds_rdata : 32'd0;
  assign r_val    = rs_rdata;
  assign t_ok     = top_r < 32'(MEM_WORDS);
  assign lit_ok   = pc1 < 32'(MEM_WORDS);
  assign ret_addr = 33'(r_val) + 33'd1;
  assign ret_ok   = ret_addr < 33'(MEM_WORDS);
  assign ic_ext   = {{23{ic_r[8]}}, ic_r};
  assign ma       = top_r[31] ? (32'd0 - top_r) : top_r;
  assign mb       = n_val[31] ? (32'd0 - n_val) : n_val;
  assign rem_sh   = {drem_r, dq_r[31]};
  assign dq_f     = dqneg_r ? (32'd0 - dq_r) : dq_r;
  assign drem_f   = drneg_r ? (32'd0 - drem_r) : drem_r;
  assign cur_top_ext = top_r;
  assign pc_ext   = 32'(pc_r);
  assign dp_ext   = 32'(dp_r);

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    pc_nxt       = pc_r;
    dp_nxt       = dp_r;
    rp_nxt       = rp_r;
    halt_nxt     = halt_r;
    top_nxt      = top_r;
    ov_nxt       = ov_r & ~out_acc;
    w_nxt        = w_r;
    ic_nxt       = ic_r;
    prod_nxt     = prod_r;
    emit_nxt     = emit_r;
    ch_nxt       = ch_r;
    wr2_addr_nxt = wr2_addr_r;
    wr2_data_nxt = wr2_data_r;
    dcnt_nxt     = dcnt_r;
    dq_nxt       = dq_r;
    drem_nxt     = drem_r;
    dd_nxt       = dd_r;
    dqneg_nxt    = dqneg_r;
    drneg_nxt    = drneg_r;
    o_emit_nxt   = o_emit_r;
    o_char_nxt   = o_char_r;
    o_status_nxt = o_status_r;
    o_pc_nxt     = o_pc_r;
    o_top_nxt    = o_top_r;
    o_depth_nxt  = o_depth_r;

    mm_we = 1'b0; mm_waddr = clr_r; mm_wdata = 32'd0;
    mm_re = 1'b0; mm_raddr = pc_r;
    ds_we = 1'b0; ds_waddr = dp_r[DAW-1:0]; ds_wdata = 32'd0;
    ds_re = 1'b0; ds_raddr = dpm2w[DAW-1:0];
    rs_we = 1'b0; rs_waddr = rp_r[RAW-1:0]; rs_wdata = 32'd0;
    rs_re = 1'b0; rs_raddr = rpm1[RAW-1:0];
    err    = dsp_pkg::ST_RUN;
    nxt_pc = pc1;

    case (state_r)
      dsp_pkg::S_CLEAR: begin
        mm_we    = 1'b1;
        mm_waddr = clr_r;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = dsp_pkg::S_IDLE;
        end
      end

      dsp_pkg::S_IDLE: begin
        if (in_acc) begin
          if (!in_opcode || halt_r != dsp_pkg::ST_RUN) begin
            if (!in_opcode && 32'(in_load_address) < 32'(MEM_WORDS)) begin
              mm_we    = 1'b1;
              mm_waddr = AW'(in_load_address);
              mm_wdata = in_load_word;
            end
            ov_nxt       = 1'b1;
            o_emit_nxt   = 1'b0;
            o_char_nxt   = 8'd0;
            o_status_nxt = halt_r;
            o_pc_nxt     = pc_ext[15:0];
            o_top_nxt    = cur_top_ext;
            o_depth_nxt  = dp_ext[5:0];
          end else begin
            mm_re     = 1'b1;
            mm_raddr  = pc_r;
            ds_re     = 1'b1;
            rs_re     = 1'b1;
            ic_nxt    = in_in_char;
            state_nxt = dsp_pkg::S_READ;
          end
        end
      end

      dsp_pkg::S_READ: begin
        // instruction word is here; fetch the operand word next
        w_nxt    = mm_rdata;
        mm_re    = 1'b1;
        mm_raddr = (mm_rdata == 32'(dsp_pkg::OP_LIT)) ? AW'(pc1) : top_r[AW-1:0];
        prod_nxt = 32'(n_val * top_r);
        state_nxt = dsp_pkg::S_EXEC;
      end

      dsp_pkg::S_EXEC: begin
        dsp_pkg::op_t op;
        logic         halt_end, go_div, go_wr2, cmp;
        logic [DPW-1:0] dpn;
        logic [RPW-1:0] rpn;
        op       = dsp_pkg::op_t'(w_r[4:0]);
        halt_end = 1'b0;
        go_div   = 1'b0;
        go_wr2   = 1'b0;
        cmp      = 1'b0;
        dpn      = dp_r;
        rpn      = rp_r;
        emit_nxt = (w_r == 32'(dsp_pkg::OP_OUT)) && dp_ge1;
        ch_nxt   = top_r[7:0] & dsp_pkg::CHAR_MASK;

        if (w_r >= dsp_pkg::NUM_OPS) begin
          err = dsp_pkg::ST_BAD_OP;
        end else begin
          case (op)
            dsp_pkg::OP_NOP: ;
            dsp_pkg::OP_LIT: begin
              if (dp_full) err = dsp_pkg::ST_OVER;
              else if (!lit_ok) err = dsp_pkg::ST_BAD_ADDR;
              else begin
                ds_we = 1'b1; ds_waddr = dp_r[DAW-1:0]; ds_wdata = mm_rdata;
                dpn = dpp1; nxt_pc = pc32 + 32'd2;
              end
            end
            dsp_pkg::OP_DUP: begin
              if (!dp_ge1) err = dsp_pkg::ST_UNDER;
              else if (dp_full) err = dsp_pkg::ST_OVER;
              else begin
                ds_we = 1'b1; ds_waddr = dp_r[DAW-1:0]; ds_wdata = top_r; dpn = dpp1;
              end
            end
            dsp_pkg::OP_DROP, dsp_pkg::OP_OUT: begin
              if (!dp_ge1) err = dsp_pkg::ST_UNDER;
              else dpn = dpm1;
            end
            dsp_pkg::OP_SWAP: begin
              if (!dp_ge2) err = dsp_pkg::ST_UNDER;
              else begin
                ds_we = 1'b1; ds_waddr = dpm1[DAW-1:0]; ds_wdata = n_val;
                go_wr2 = 1'b1;
                wr2_addr_nxt = dpm2[DAW-1:0];
                wr2_data_nxt = top_r;
              end
            end
            dsp_pkg::OP_PUSH: begin
              if (!dp_ge1) err = dsp_pkg::ST_UNDER;
              else if (rp_full) err = dsp_pkg::ST_OVER;
              else begin
                rs_we = 1'b1; rs_waddr = rp_r[RAW-1:0]; rs_wdata = top_r;
                rpn = rpp1; dpn = dpm1;
              end
            end
            dsp_pkg::OP_POP: begin
              if (!rp_ge1) err = dsp_pkg::ST_UNDER;
              else if (dp_full) err = dsp_pkg::ST_OVER;
              else begin
                ds_we = 1'b1; ds_waddr = dp_r[DAW-1:0]; ds_wdata = r_val;
                dpn = dpp1; rpn = rpm1;
              end
            end
            dsp_pkg::OP_JUMP: begin
              if (!dp_ge1) err = dsp_pkg::ST_UNDER;
              else if (!t_ok) err = dsp_pkg::ST_BAD_ADDR;
              else begin dpn = dpm1; nxt_pc = top_r; end
            end
            dsp_pkg::OP_CALL: begin
              if (!dp_ge1) err = dsp_pkg::ST_UNDER;
              else if (rp_full) err = dsp_pkg::ST_OVER;
              else if (!t_ok) err = dsp_pkg::ST_BAD_ADDR;
              else begin
                rs_we = 1'b1; rs_waddr = rp_r[RAW-1:0]; rs_wdata = pc32;
                rpn = rpp1; dpn = dpm1; nxt_pc = top_r;
              end
            end
            dsp_pkg::OP_CCALL: begin
              if (!dp_ge2) err = dsp_pkg::ST_UNDER;
              else if (n_val != 32'd0) begin
                if (rp_full) err = dsp_pkg::ST_OVER;
                else if (!t_ok) err = dsp_pkg::ST_BAD_ADDR;
                else begin
                  rs_we = 1'b1; rs_waddr = rp_r[RAW-1:0]; rs_wdata = pc32;
                  rpn = rpp1; dpn = dpm2; nxt_pc = top_r;
                end
              end else dpn = dpm2;
            end
            dsp_pkg::OP_RETURN: begin
              if (!rp_ge1) err = dsp_pkg::ST_UNDER;
              else if (!ret_ok) err = dsp_pkg::ST_BAD_ADDR;
              else begin rpn = rpm1; nxt_pc = ret_addr[31:0]; end
            end
            dsp_pkg::OP_ZRET: begin
              if (!dp_ge1) err = dsp_pkg::ST_UNDER;
              else if (top_r == 32'd0) begin
                if (!rp_ge1) err = dsp_pkg::ST_UNDER;
                else if (!ret_ok) err = dsp_pkg::ST_BAD_ADDR;
                else begin rpn = rpm1; dpn = dpm1; nxt_pc = ret_addr[31:0]; end
              end
            end
            dsp_pkg::OP_EQ, dsp_pkg::OP_NEQ, dsp_pkg::OP_LT, dsp_pkg::OP_GT: begin
              if (op == dsp_pkg::OP_EQ)       cmp = n_val == top_r;
              else if (op == dsp_pkg::OP_NEQ) cmp = n_val != top_r;
              else if (op == dsp_pkg::OP_LT)  cmp = $signed(n_val) < $signed(top_r);
              else                            cmp = $signed(top_r) < $signed(n_val);
              if (!dp_ge2) err = dsp_pkg::ST_UNDER;
              else begin
                ds_we = 1'b1; ds_waddr = dpm2[DAW-1:0]; ds_wdata = {32{cmp}};
                dpn = dpm1;
              end
            end
            dsp_pkg::OP_FETCH: begin
              if (!dp_ge1) err = dsp_pkg::ST_UNDER;
              else if (!t_ok) err = dsp_pkg::ST_BAD_ADDR;
              else begin
                ds_we = 1'b1; ds_waddr = dpm1[DAW-1:0]; ds_wdata = mm_rdata;
              end
            end
            dsp_pkg::OP_STORE: begin
              if (!dp_ge2) err = dsp_pkg::ST_UNDER;
              else if (!t_ok) err = dsp_pkg::ST_BAD_ADDR;
              else begin
                mm_we = 1'b1; mm_waddr = top_r[AW-1:0]; mm_wdata = n_val;
                dpn = dpm2;
              end
            end
            dsp_pkg::OP_ADD, dsp_pkg::OP_SUB, dsp_pkg::OP_MUL, dsp_pkg::OP_AND,
            dsp_pkg::OP_OR, dsp_pkg::OP_XOR, dsp_pkg::OP_SHIFT: begin
              if (!dp_ge2) err = dsp_pkg::ST_UNDER;
              else begin
                ds_we = 1'b1; ds_waddr = dpm2[DAW-1:0]; dpn = dpm1;
                case (op)
                  dsp_pkg::OP_ADD: ds_wdata = n_val + top_r;
                  dsp_pkg::OP_SUB: ds_wdata = n_val - top_r;
                  dsp_pkg::OP_MUL: ds_wdata = prod_r;
                  dsp_pkg::OP_AND: ds_wdata = n_val & top_r;
                  dsp_pkg::OP_OR:  ds_wdata = n_val | top_r;
                  dsp_pkg::OP_XOR: ds_wdata = n_val ^ top_r;
                  default:         ds_wdata = dsp_pkg::shift_op(n_val, top_r);
                endcase
              end
            end
            dsp_pkg::OP_DIVMOD: begin
              if (!dp_ge2) err = dsp_pkg::ST_UNDER;
              else if (top_r == 32'd0) err = dsp_pkg::ST_DIV_ZERO;
              else begin
                go_div    = 1'b1;
                dd_nxt    = ma;
                dq_nxt    = mb;
                drem_nxt  = 32'd0;
                dcnt_nxt  = 5'd0;
                dqneg_nxt = top_r[31] ^ n_val[31];
                drneg_nxt = n_val[31];
              end
            end
            dsp_pkg::OP_END, dsp_pkg::OP_CJUMP: halt_end = 1'b1;
            dsp_pkg::OP_IN: begin
              if (dp_full) err = dsp_pkg::ST_OVER;
              else begin
                ds_we = 1'b1; ds_waddr = dp_r[DAW-1:0]; ds_wdata = ic_ext; dpn = dpp1;
              end
            end
            default: err = dsp_pkg::ST_BAD_OP;
          endcase
        end

        if (halt_end) begin
          halt_nxt  = dsp_pkg::ST_END;
          state_nxt = dsp_pkg::S_RESP;
        end else if (err != dsp_pkg::ST_RUN) begin
          // faulting instruction leaves stacks, pointers, pc and memory alone; only the halt status changes
          ds_we = 1'b0; rs_we = 1'b0; mm_we = 1'b0;
          halt_nxt  = err;
          state_nxt = dsp_pkg::S_RESP;
        end else begin
          dp_nxt = dpn;
          rp_nxt = rpn;
          if (nxt_pc < 32'(MEM_WORDS)) pc_nxt = nxt_pc[AW-1:0];
          else halt_nxt = dsp_pkg::ST_BAD_ADDR;
          if (go_div)      state_nxt = dsp_pkg::S_DIV;
          else if (go_wr2) state_nxt = dsp_pkg::S_WR2;
          else             state_nxt = dsp_pkg::S_REFILL;
        end
      end

      dsp_pkg::S_DIV: begin
        // one restoring step per cycle on the magnitudes
        if (rem_sh >= {1'b0, dd_r}) begin
          drem_nxt = 32'(rem_sh - {1'b0, dd_r});
          dq_nxt   = {dq_r[30:0], 1'b1};
        end else begin
          drem_nxt = rem_sh[31:0];
          dq_nxt   = {dq_r[30:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) state_nxt = dsp_pkg::S_DIV_WR;
      end

      dsp_pkg::S_DIV_WR: begin
        ds_we = 1'b1; ds_waddr = dpm1[DAW-1:0]; ds_wdata = dq_f;
        wr2_addr_nxt = dpm2[DAW-1:0];
        wr2_data_nxt = drem_f;
        state_nxt    = dsp_pkg::S_WR2;
      end

      dsp_pkg::S_WR2: begin
        ds_we = 1'b1; ds_waddr = wr2_addr_r; ds_wdata = wr2_data_r;
        state_nxt = dsp_pkg::S_REFILL;
      end

      dsp_pkg::S_REFILL: begin
        ds_re     = 1'b1;
        ds_raddr  = dpm1[DAW-1:0];
        state_nxt = dsp_pkg::S_TOP;
      end

      dsp_pkg::S_TOP: begin
        top_nxt   = dp_ge1 ? ds_rdata : 32'd0;
        state_nxt = dsp_pkg::S_RESP;
      end

      dsp_pkg::S_RESP: begin
        if (slot_free) begin
          ov_nxt       = 1'b1;
          o_emit_nxt   = emit_r;
          o_char_nxt   = emit_r ? ch_r : 8'd0;
          o_status_nxt = halt_r;
          o_pc_nxt     = pc_ext[15:0];
          o_top_nxt    = top_r;
          o_depth_nxt  = dp_ext[5:0];
          state_nxt    = dsp_pkg::S_IDLE;
        end
      end

      default: state_nxt = dsp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsp_pkg::S_CLEAR;
      clr_r   <= '0;
      pc_r    <= '0;
      dp_r    <= '0;
      rp_r    <= '0;
      halt_r  <= dsp_pkg::ST_RUN;
      top_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
      dp_r    <= dp_nxt;
      rp_r    <= rp_nxt;
      halt_r  <= halt_nxt;
      top_r   <= top_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    ic_r       <= ic_nxt;
    prod_r     <= prod_nxt;
    emit_r     <= emit_nxt;
    ch_r       <= ch_nxt;
    wr2_addr_r <= wr2_addr_nxt;
    wr2_data_r <= wr2_data_nxt;
    dcnt_r     <= dcnt_nxt;
    dq_r       <= dq_nxt;
    drem_r     <= drem_nxt;
    dd_r       <= dd_nxt;
    dqneg_r    <= dqneg_nxt;
    drneg_r    <= drneg_nxt;
    o_emit_r   <= o_emit_nxt;
    o_char_r   <= o_char_nxt;
    o_status_r <= o_status_nxt;
    o_pc_r     <= o_pc_nxt;
    o_top_r    <= o_top_nxt;
    o_depth_r  <= o_depth_nxt;
  end

  assign out_valid       = ov_r;
  assign out_out_valid   = o_emit_r;
  assign out_out_char    = o_char_r;
  assign out_status      = o_status_r;
  assign out_pc_value    = o_pc_r;
  assign out_top_value   = o_top_r;
  assign out_stack_depth = o_depth_r;

endmodule

/* rtl/dsp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module dsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/dsp_checker.sv */
// Port-level checker for the dual-stack processor core, bound to the top level.
// Depends on dsp_pkg and dual_stack_processor_core_assert.svh.
`include "dual_stack_processor_core_assert.svh"

module dsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_out_valid,
  input logic [7:0]  out_out_char,
  input logic [2:0]  out_status,
  input logic [15:0] out_pc_value
);

  // stalled result beat holds
  `DSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_pc_value), "result beat changed under stall")

  // no character without an emit
  `DSP_ASSERT_NOW(a_char_quiet, clk, rst_n, out_valid && !out_out_valid,
    out_out_char == 8'd0, "character set without emit")

  // status codes stop at bad address
  `DSP_ASSERT_NOW(a_status_range, clk, rst_n, out_valid,
    out_status <= dsp_pkg::ST_BAD_ADDR, "status code out of range")

  // OUT either runs on or steps off the end of memory
  `DSP_ASSERT_NOW(a_emit_status, clk, rst_n, out_valid && out_out_valid,
    out_status == dsp_pkg::ST_RUN || out_status == dsp_pkg::ST_BAD_ADDR,
    "emit with unexpected status")

endmodule

bind dual_stack_processor_core dsp_checker u_dsp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_out_valid(out_out_valid),
  .out_out_char(out_out_char),
  .out_status(out_status),
  .out_pc_value(out_pc_value)
);

/* verif/tb_top.sv */
// Testbench for the dual-stack processor core: loads programs, executes them beat by beat
// and checks every result against an in-bench machine model. Depends on dsp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import dsp_pkg::*;

  localparam int MEM_CELLS = 65536;
  localparam int DSTK_MAX  = 32;
  localparam int RSTK_MAX  = 128;
  localparam int IDLE_LIMIT = 300000;

  typedef struct packed {
    logic        emit;
    logic [7:0]  ch;
    logic [2:0]  st;
    logic [15:0] pc;
    logic [31:0] top;
    logic [5:0]  depth;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_opcode = 1'b0;
  logic [15:0] in_load_address = '0;
  logic signed [31:0] in_load_word = '0;
  logic signed [8:0] in_in_char = '0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, out_out_valid;
  logic [7:0] out_out_char;
  logic [2:0] out_status;
  logic [15:0] out_pc_value;
  logic signed [31:0] out_top_value;
  logic [5:0] out_stack_depth;

  dual_stack_processor_core u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // machine model
  logic [31:0] mem_m [MEM_CELLS];
  logic [31:0] dstk [DSTK_MAX];
  logic [31:0] rstk [RSTK_MAX];
  int unsigned dpm, rpm, pcm;
  logic [2:0] halt_m;

  result_t pending_results[$];
  int errors = 0;
  bit calm = 0;

  function automatic logic [31:0] shift_word(logic [31:0] x, logic [31:0] amt);
    logic [31:0] mag;
    mag = 32'd0 - amt;
    if (amt[31]) return (mag >= 32) ? 32'd0 : x << mag[4:0];
    if (amt >= 32) return {32{x[31]}};
    return $signed(x) >>> amt[4:0];
  endfunction

  // runs the instruction at pcm; dry leaves the model untouched
  function automatic logic [2:0] run_instr(bit dry, logic [8:0] ch);
    logic [31:0] ds [DSTK_MAX];
    logic [31:0] rs [RSTK_MAX];
    int unsigned dp, rp;
    longint unsigned nxt, ret;
    logic [31:0] w, t, n, r, q, ma, mb;
    logic [2:0] err;
    bit c, wr_en;
    logic [31:0] wr_a, wr_d;
    ds = dstk; rs = rstk; dp = dpm; rp = rpm;
    w = mem_m[pcm];
    nxt = pcm + 1;
    t = (dp >= 1) ? ds[dp-1] : 32'd0;
    n = (dp >= 2) ? ds[dp-2] : 32'd0;
    err = ST_RUN;
    wr_en = 0; wr_a = 0; wr_d = 0;
    case (w)
      OP_NOP: ;
      OP_LIT:
        if (dp >= DSTK_MAX) err = ST_OVER;
        else if (pcm + 1 >= MEM_CELLS) err = ST_BAD_ADDR;
        else begin ds[dp] = mem_m[pcm+1]; dp++; nxt = pcm + 2; end
      OP_DUP:
        if (dp < 1) err = ST_UNDER;
        else if (dp >= DSTK_MAX) err = ST_OVER;
        else begin ds[dp] = t; dp++; end
      OP_DROP, OP_OUT:
        if (dp < 1) err = ST_UNDER; else dp--;
      OP_SWAP:
        if (dp < 2) err = ST_UNDER;
        else begin ds[dp-1] = n; ds[dp-2] = t; end
      OP_PUSH:
        if (dp < 1) err = ST_UNDER;
        else if (rp >= RSTK_MAX) err = ST_OVER;
        else begin rs[rp] = t; rp++; dp--; end
      OP_POP:
        if (rp < 1) err = ST_UNDER;
        else if (dp >= DSTK_MAX) err = ST_OVER;
        else begin ds[dp] = rs[rp-1]; dp++; rp--; end
      OP_JUMP:
        if (dp < 1) err = ST_UNDER;
        else if (t >= MEM_CELLS) err = ST_BAD_ADDR;
        else begin dp--; nxt = t; end
      OP_CALL:
        if (dp < 1) err = ST_UNDER;
        else if (rp >= RSTK_MAX) err = ST_OVER;
        else if (t >= MEM_CELLS) err = ST_BAD_ADDR;
        else begin rs[rp] = pcm; rp++; dp--; nxt = t; end
      OP_CCALL:
        if (dp < 2) err = ST_UNDER;
        else if (n != 0) begin
          if (rp >= RSTK_MAX) err = ST_OVER;
          else if (t >= MEM_CELLS) err = ST_BAD_ADDR;
          else begin rs[rp] = pcm; rp++; dp -= 2; nxt = t; end
        end else dp -= 2;
      OP_RETURN, OP_ZRET:
        if (w == OP_ZRET && dp < 1) err = ST_UNDER;
        else if (w == OP_ZRET && t != 0) ;
        else if (rp < 1) err = ST_UNDER;
        else begin
          ret = longint'(rs[rp-1]) + 1;
          if (ret >= MEM_CELLS) err = ST_BAD_ADDR;
          else begin rp--; nxt = ret; if (w == OP_ZRET) dp--; end
        end
      OP_EQ, OP_NEQ, OP_LT, OP_GT:
        if (dp < 2) err = ST_UNDER;
        else begin
          case (w)
            OP_EQ:   c = (n == t);
            OP_NEQ:  c = (n != t);
            OP_LT:   c = ($signed(n) < $signed(t));
            default: c = ($signed(t) < $signed(n));
          endcase
          ds[dp-2] = c ? 32'hffff_ffff : 32'd0;
          dp--;
        end
      OP_FETCH:
        if (dp < 1) err = ST_UNDER;
        else if (t >= MEM_CELLS) err = ST_BAD_ADDR;
        else ds[dp-1] = mem_m[t];
      OP_STORE:
        if (dp < 2) err = ST_UNDER;
        else if (t >= MEM_CELLS) err = ST_BAD_ADDR;
        else begin wr_en = 1; wr_a = t; wr_d = n; dp -= 2; end
      OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_SHIFT:
        if (dp < 2) err = ST_UNDER;
        else begin
          case (w)
            OP_ADD:  r = n + t;
            OP_SUB:  r = n - t;
            OP_MUL:  r = n * t;
            OP_AND:  r = n & t;
            OP_OR:   r = n | t;
            OP_XOR:  r = n ^ t;
            default: r = shift_word(n, t);
          endcase
          ds[dp-2] = r;
          dp--;
        end
      OP_DIVMOD:
        if (dp < 2) err = ST_UNDER;
        else if (t == 0) err = ST_DIV_ZERO;
        else begin
          ma = t[31] ? -t : t;
          mb = n[31] ? -n : n;
          q = mb / ma;
          r = mb % ma;
          if (t[31] != n[31]) q = -q;
          if (n[31]) r = -r;
          ds[dp-1] = q;
          ds[dp-2] = r;
        end
      OP_END, OP_CJUMP: err = ST_END;
      OP_IN:
        if (dp >= DSTK_MAX) err = ST_OVER;
        else begin ds[dp] = {{23{ch[8]}}, ch}; dp++; end
      default: err = ST_BAD_OP;
    endcase
    if (err != ST_RUN) begin
      if (!dry) halt_m = err;
      return err;
    end
    if (!dry) begin
      dstk = ds; rstk = rs; dpm = dp; rpm = rp;
      if (wr_en) mem_m[wr_a] = wr_d;
      if (nxt >= MEM_CELLS) halt_m = ST_BAD_ADDR;
      else pcm = nxt;
    end
    return (nxt >= MEM_CELLS) ? ST_BAD_ADDR : ST_RUN;
  endfunction

  function automatic result_t predict_step(bit op, logic [15:0] a, logic [31:0] d,
                                           logic [8:0] ch);
    result_t res;
    logic [2:0] st;
    res = '0;
    if (!op) mem_m[a] = d;
    else if (halt_m == ST_RUN) begin
      if (mem_m[pcm] == OP_OUT && dpm >= 1) begin
        res.emit = 1'b1;
        res.ch = dstk[dpm-1][7:0] & CHAR_MASK;
      end
      st = run_instr(0, ch);
    end
    res.st = halt_m;
    res.pc = pcm[15:0];
    res.top = (dpm >= 1) ? dstk[dpm-1] : 32'd0;
    res.depth = dpm[5:0];
    return res;
  endfunction

  task automatic send_beat(bit op, logic [15:0] a, logic [31:0] d, logic [8:0] ch);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_load_address <= a;
    in_load_word <= d;
    in_in_char <= ch;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_step(op, a, d, ch));
  endtask

  // places the instruction (and a literal operand) at the pc, then runs it
  task automatic exec_word(logic [31:0] w, logic [31:0] operand, logic [8:0] ch);
    send_beat(1'b0, pcm[15:0], w, $urandom);
    if (w == OP_LIT) send_beat(1'b0, 16'(pcm + 1), operand, $urandom);
    send_beat(1'b1, $urandom, $urandom, ch);
  endtask

  task automatic lit(logic [31:0] v);
    exec_word(OP_LIT, v, $urandom);
  endtask

  task automatic op(op_t o);
    exec_word(o, $urandom, $urandom);
  endtask

  // picks an instruction that the model says will not halt the core
  task automatic rand_instr();
    logic [31:0] w, keep0, keep1, opnd;
    logic [8:0] ch;
    logic [2:0] st;
    bit found;
    found = 0;
    w = OP_NOP;
    ch = $urandom;
    opnd = ($urandom_range(0, 1)) ? $urandom_range(0, 1023) : $urandom;
    keep0 = mem_m[pcm];
    keep1 = mem_m[pcm+1];
    for (int i = 0; i < 16 && !found; i++) begin
      w = $urandom_range(0, 29);
      if (w == OP_END || w == OP_CJUMP) continue;
      mem_m[pcm] = w;
      mem_m[pcm+1] = opnd;
      st = run_instr(1, ch);
      found = (st == ST_RUN);
    end
    mem_m[pcm] = keep0;
    mem_m[pcm+1] = keep1;
    if (!found) w = OP_NOP;
    exec_word(w, opnd, ch);
  endtask

  task automatic test_directed();
    lit(32'h8000_0000); lit(32'hffff_ffff); op(OP_DIVMOD);
    lit(32'd7); lit(-32'sd2); op(OP_DIVMOD);
    lit(32'd1); lit(-32'sd4); op(OP_SHIFT);
    lit(32'd40); op(OP_SHIFT); lit(-32'sd40); op(OP_SHIFT);
    lit(32'h7fff_ffff); op(OP_DUP); op(OP_ADD); op(OP_DUP); op(OP_MUL);
    lit(32'd3); lit(-32'sd3); op(OP_LT); op(OP_DROP);
    lit(32'd3); lit(-32'sd3); op(OP_GT);
    lit(32'd9); op(OP_EQ); lit(32'd9); op(OP_NEQ);
    op(OP_SWAP); op(OP_SUB); op(OP_AND); op(OP_OR); op(OP_XOR);
    lit(32'd5); lit(32'd500); op(OP_STORE); lit(32'd500); op(OP_FETCH);
    op(OP_PUSH); op(OP_POP); op(OP_NOP);
    exec_word(OP_IN, 0, 9'h1ff); exec_word(OP_IN, 0, 9'h0ff); op(OP_OUT); op(OP_OUT);
    // conditional call, not taken then taken, followed by both zero-return cases
    lit(32'd0); lit(32'd3000); op(OP_CCALL);
    lit(32'd1); lit(32'd3000); op(OP_CCALL);
    lit(32'd1); op(OP_ZRET); op(OP_DROP);
    lit(32'd0); op(OP_ZRET);
    lit(32'd1200); op(OP_CALL); op(OP_RETURN);
    lit(32'd100); op(OP_JUMP);
    send_beat(1'b0, 16'hffff, 32'hffff_ffff, 9'h0);
    send_beat(1'b0, 16'h0000, 32'h0, 9'h1ff);
  endtask

  task automatic test_random(int beats);
    int sent;
    sent = 0;
    while (sent < beats) begin
      if (pcm > 20000) begin
        lit($urandom_range(0, 1023)); op(OP_JUMP);
      end else if ($urandom_range(0, 7) == 0) begin
        send_beat(1'b0, $urandom, $urandom, $urandom);
      end else if ($urandom_range(0, 3) == 0) begin
        lit($urandom_range(0, 1023));
      end else begin
        rand_instr();
      end
      sent++;
    end
  endtask

  // one halt per run: the seed picks which end or fault stops the core
  task automatic test_halt();
    case ($urandom_range(0, 7))
      0: op(OP_END);
      1: op(OP_CJUMP);
      2: exec_word($urandom_range(30, 32'hffff_ffff), 0, 0);
      3: begin lit(32'd5); lit(32'd0); op(OP_DIVMOD); end
      4: begin while (dpm > 0) op(OP_DROP); op(OP_DROP); end
      5: begin while (dpm < DSTK_MAX) op(OP_IN); op(OP_IN); end
      6: begin lit(32'h0001_2345); op(OP_FETCH); end
      default: begin
        lit(32'hfffe); op(OP_JUMP);
        send_beat(1'b0, 16'hfffe, OP_NOP, 0);
        send_beat(1'b0, 16'hffff, OP_NOP, 0);
        send_beat(1'b1, 0, 0, 0);
        send_beat(1'b1, 0, 0, 0);
      end
    endcase
  endtask

  task automatic test_halted();
    repeat (6) begin
      send_beat(1'b1, $urandom, $urandom, $urandom);
      send_beat(1'b0, $urandom_range(0, 1023), $urandom, $urandom);
    end
  endtask

  // receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_out_valid !== want.emit) begin
          $error("out_valid exp %0d got %0d", want.emit, out_out_valid); errors++;
        end
        if (out_out_char !== want.ch) begin
          $error("out_char exp %0h got %0h", want.ch, out_out_char); errors++;
        end
        if (out_status !== want.st) begin
          $error("status exp %0d got %0d", want.st, out_status); errors++;
        end
        if (out_pc_value !== want.pc) begin
          $error("pc_value exp %0h got %0h", want.pc, out_pc_value); errors++;
        end
        if (out_top_value !== want.top) begin
          $error("top_value exp %0h got %0h", want.top, out_top_value); errors++;
        end
        if (out_stack_depth !== want.depth) begin
          $error("stack_depth exp %0d got %0d", want.depth, out_stack_depth); errors++;
        end
      end
    end
  end

  // covers the clearing pass after reset as well as the longest divide
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MEM_CELLS; i++) mem_m[i] = '0;
    for (int i = 0; i < DSTK_MAX; i++) dstk[i] = '0;
    for (int i = 0; i < RSTK_MAX; i++) rstk[i] = '0;
    dpm = 0; rpm = 0; pcm = 0; halt_m = ST_RUN;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1300);
    calm = 1;
    test_random(300);
    test_halt();
    test_halted();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* dual_stack_processor_core.f */
+incdir+rtl
rtl/dsp_pkg.sv
rtl/dsp_ram.sv
rtl/dual_stack_processor_core.sv
rtl/dsp_checker.sv
verif/tb_top.sv
